// ----- rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with indexed read.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

	localparam int CAPACITY     = 256;
	localparam int ELEMENT_BITS = 32;

	localparam int PTR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int WORD_W = 32;
	localparam int POS_W  = 8;
	localparam int OCC_W  = 9;

	typedef logic [ELEMENT_BITS-1:0] elem_t;
	typedef logic [PTR_W-1:0]        ptr_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	typedef enum logic [2:0] {
		CMD_INS_HEAD = 3'd0,
		CMD_INS_TAIL = 3'd1,
		CMD_REM_HEAD = 3'd2,
		CMD_REM_TAIL = 3'd3,
		CMD_RD_HEAD  = 3'd4,
		CMD_RD_TAIL  = 3'd5,
		CMD_RD_INDEX = 3'd6
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]        cmd;
		logic [WORD_W-1:0] element_in;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] element_out;
		logic [OCC_W-1:0]  occupancy;
		status_t           status;
	} rsp_t;

endpackage

`default_nettype wire

// ----- rtl/bounded_deque_with_index_read.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_index_read
// Double-ended queue held in a circular buffer RAM, with indexed read.
//
// Request channel (req_valid / req_stall / req) carries one command per
// transaction: insert or remove at head or tail, read head, tail or index.
// Response channel (rsp_valid / rsp_stall / rsp) returns one result per
// command, in order: the word read, the occupancy after the command and a
// status code.
// Response path: the RAM read data is registered at the accepting edge
// (stage 1), then moves to the output register once that register is free.
// Throughput: one command per cycle while req_stall is low; every command
// touches at most one RAM entry and the head pointer and count update in
// the cycle of acceptance. A stalled response holds in the output register;
// the stage behind it still takes one more command, after which req_stall
// is raised until the output register drains.
// Reset clears the head pointer, the count and all valid flags; the RAM
// content is not cleared, and only entries holding live words are read.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_index_read (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire bdq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output bdq_pkg::rsp_t      rsp
);
	import bdq_pkg::*;

	localparam int SUM_W = CNT_W + 1;

	elem_t ram [CAPACITY];

	ptr_t head_q;
	cnt_t cnt_q;

	// stage 1: RAM read in flight
	logic    valid_s1;
	logic    rd_s1;
	cnt_t    cnt_s1;
	status_t status_s1;
	elem_t   rdata_s1;

	// output register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic    accept;
	logic    adv_s1;
	logic    full;
	logic    empty;
	logic    wr_en;
	logic    rd_en;
	ptr_t    wr_addr;
	ptr_t    rd_addr;
	ptr_t    head_nx;
	cnt_t    cnt_nx;
	status_t status_nx;
	logic    pos_ok;

	function automatic ptr_t slot_add(ptr_t base, cnt_t off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(CAPACITY))
			sum = sum - SUM_W'(CAPACITY);
		return PTR_W'(sum);
	endfunction

	assign adv_s1    = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv_s1;
	assign accept    = req_valid && !req_stall;

	assign full   = (cnt_q == CNT_W'(CAPACITY));
	assign empty  = (cnt_q == '0);
	assign pos_ok = (SUM_W'(req.position) < SUM_W'(cnt_q));

	always_comb begin
		head_nx   = head_q;
		cnt_nx    = cnt_q;
		status_nx = ST_OK;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		wr_addr   = head_q;
		rd_addr   = head_q;
		case (req.cmd)
			CMD_INS_HEAD: begin
				if (full) begin
					status_nx = ST_FULL;
				end else begin
					head_nx = slot_add(head_q, CNT_W'(CAPACITY - 1));
					wr_addr = head_nx;
					wr_en   = 1'b1;
					cnt_nx  = cnt_q + 1'b1;
				end
			end
			CMD_INS_TAIL: begin
				if (full) begin
					status_nx = ST_FULL;
				end else begin
					wr_addr = slot_add(head_q, cnt_q);
					wr_en   = 1'b1;
					cnt_nx  = cnt_q + 1'b1;
				end
			end
			CMD_REM_HEAD: begin
				if (empty) begin
					status_nx = ST_EMPTY;
				end else begin
					head_nx = slot_add(head_q, CNT_W'(1));
					cnt_nx  = cnt_q - 1'b1;
				end
			end
			CMD_REM_TAIL: begin
				if (empty)
					status_nx = ST_EMPTY;
				else
					cnt_nx = cnt_q - 1'b1;
			end
			CMD_RD_HEAD: begin
				if (empty)
					status_nx = ST_EMPTY;
				else
					rd_en = 1'b1;
			end
			CMD_RD_TAIL: begin
				if (empty) begin
					status_nx = ST_EMPTY;
				end else begin
					rd_addr = slot_add(head_q, cnt_q - 1'b1);
					rd_en   = 1'b1;
				end
			end
			CMD_RD_INDEX: begin
				if (empty) begin
					status_nx = ST_EMPTY;
				end else if (!pos_ok) begin
					status_nx = ST_RANGE;
				end else begin
					rd_addr = slot_add(head_q, CNT_W'(req.position));
					rd_en   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// RAM: one write or one read per command, read data registered
	always_ff @(posedge clk) begin
		if (accept && wr_en)
			ram[wr_addr] <= elem_t'(req.element_in);
		if (accept && rd_en)
			rdata_s1 <= ram[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q <= head_nx;
				cnt_q  <= cnt_nx;
			end
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv_s1)
				valid_s1 <= 1'b0;
			if (adv_s1)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= rd_en;
			cnt_s1    <= cnt_nx;
			status_s1 <= status_nx;
		end
		if (adv_s1) begin
			rsp_q.element_out <= rd_s1 ? WORD_W'(rdata_s1) : '0;
			rsp_q.occupancy   <= OCC_W'(cnt_s1);
			rsp_q.status      <= status_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/bdq_checker.sv -----
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks on the deque responses, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire bdq_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire bdq_pkg::rsp_t rsp
);
	import bdq_pkg::*;

	// a rejected insert only happens with the list at capacity
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.occupancy == OCC_W'(CAPACITY))
		else $error("full status with occupancy below capacity");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.occupancy == '0)
		else $error("empty status with non-zero occupancy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.element_out == '0)
		else $error("failed transaction returned a word");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// input is only held off behind a stalled response
	a_req_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |-> rsp_valid && rsp_stall ##1 req_valid && $stable(req))
		else $error("request stalled without a stalled response, or changed while stalled");

endmodule

bind bounded_deque_with_index_read bdq_checker u_bdq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
